// ===== hdl/cgn_pkg.sv =====
`default_nettype none

package cgn_pkg;

  localparam int IDX_W    = 18;
  localparam int DIM_W    = 7;
  localparam int PLANE_W  = 2 * DIM_W;
  localparam int DIV_W    = PLANE_W + DIM_W;
  localparam int OUT_CW   = 6;
  localparam int PC_W     = 3;
  localparam int TC_W     = 5;
  localparam int STEP_W   = $clog2(DIM_W);
  localparam int REG_IDX_W = 2;

  localparam int MAX_CELLS_DEFAULT = 64;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  typedef logic signed [1:0] ofs_t;
  localparam ofs_t OFS_NEG  = 2'sb11;
  localparam ofs_t OFS_ZERO = 2'sb00;
  localparam ofs_t OFS_POS  = 2'sb01;

  typedef struct packed {
    logic [DIM_W-1:0]   cx;
    logic [DIM_W-1:0]   cy;
    logic [DIM_W-1:0]   cz;
    logic [PLANE_W-1:0] plane;
  } dims_t;

  typedef struct packed {
    logic             invalid;
    logic [IDX_W-1:0] idx;
    logic [DIM_W-1:0] bx;
    logic [DIM_W-1:0] by;
    logic [DIM_W-1:0] bz;
    logic [PC_W-1:0]  pc;
    logic [TC_W-1:0]  tc;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]  neighbour;
    logic              last;
    logic [OUT_CW-1:0] bx;
    logic [OUT_CW-1:0] by;
    logic [OUT_CW-1:0] bz;
    logic [PC_W-1:0]   pc;
    logic [TC_W-1:0]   tc;
    logic              invalid;
  } result_t;

  // A zero dimension becomes one, anything above the limit becomes the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int max_dim);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > max_dim) begin
      return DIM_W'(max_dim);
    end
    return v;
  endfunction

  // Base-4 digits sum to the same residue mod 3 since 4 leaves remainder 1.
  function automatic logic [1:0] mod3(input logic [DIM_W-1:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    return (s2 >= 3'd3) ? 2'(s2 - 3'd3) : s2[1:0];
  endfunction

  function automatic ofs_t low_ofs(input logic [DIM_W-1:0] c);
    return (c == '0) ? OFS_ZERO : OFS_NEG;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cgn_fifo.sv =====
`default_nettype none

module cgn_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full    = count == (AW + 1)'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/cgn_config.sv =====
`default_nettype none

module cgn_config #(
  parameter int MAX_CELLS_PER_DIM = cgn_pkg::MAX_CELLS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            write_enable,
  input  wire logic [cgn_pkg::REG_IDX_W-1:0]   reg_index,
  input  wire logic [cgn_pkg::DIM_W-1:0]       write_data,
  output cgn_pkg::dims_t                       dims
);

  import cgn_pkg::*;

  localparam logic [DIM_W-1:0]   RESET_DIM   = clamp_dim(DIM_RESET, MAX_CELLS_PER_DIM);
  localparam logic [PLANE_W-1:0] RESET_PLANE = PLANE_W'(RESET_DIM) * PLANE_W'(RESET_DIM);

  logic [DIM_W-1:0] wval;

  assign wval = clamp_dim(write_data, MAX_CELLS_PER_DIM);

  // The x*y plane size is kept alongside the dimensions so the decoder
  // never multiplies.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.cx    <= RESET_DIM;
      dims.cy    <= RESET_DIM;
      dims.cz    <= RESET_DIM;
      dims.plane <= RESET_PLANE;
    end else if (write_enable) begin
      case (reg_index)
        REG_CELLS_X: begin
          dims.cx    <= wval;
          dims.plane <= PLANE_W'(wval) * PLANE_W'(dims.cy);
        end
        REG_CELLS_Y: begin
          dims.cy    <= wval;
          dims.plane <= PLANE_W'(dims.cx) * PLANE_W'(wval);
        end
        REG_CELLS_Z: begin
          dims.cz <= wval;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cgn_decode.sv =====
`default_nettype none

module cgn_decode (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cgn_pkg::dims_t               dims,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [cgn_pkg::IDX_W-1:0]    cell_index,
  output logic                              job_push,
  output cgn_pkg::job_t                     job_wdata,
  input  wire logic                         job_full
);

  import cgn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_Z,
    S_DIV_Y,
    S_EMIT
  } state_t;

  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(DIM_W - 1);

  state_t            state;
  logic              slot_valid;
  logic [IDX_W-1:0]  slot_idx;
  logic              take;
  logic              over;
  logic              z_over;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  rem_next;
  logic [DIM_W-1:0]  quo;
  logic [DIM_W-1:0]  quo_next;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  divisor;
  logic              ge;
  job_t              base;
  job_t              base_next;

  assign take     = (state == S_IDLE) && slot_valid;
  assign full     = slot_valid && !take;
  assign job_push = (state == S_EMIT) && !job_full;

  // Anything at or past 2**DIM_W planes would give a z quotient wider than a
  // dimension register, so it is rejected before dividing.
  assign over = {{(DIV_W - IDX_W){1'b0}}, slot_idx} >= (DIV_W'(dims.plane) << DIM_W);

  // One restoring-division step per clock: first idx / plane, then rem / cx.
  assign divisor  = (state == S_DIV_Z) ? (DIV_W'(dims.plane) << step)
                                       : (DIV_W'(dims.cx) << step);
  assign ge       = {{(DIV_W - IDX_W){1'b0}}, rem} >= divisor;
  assign rem_next = ge ? rem - divisor[IDX_W-1:0] : rem;
  assign quo_next = {quo[DIM_W-2:0], ge};
  assign z_over   = quo_next >= dims.cz;

  always_comb begin
    base_next = base;
    case (state)
      S_IDLE: begin
        base_next = '0;
        if (over) begin
          base_next.invalid = 1'b1;
        end else begin
          base_next.idx = slot_idx;
        end
      end
      S_DIV_Z: begin
        if (z_over) begin
          base_next         = '0;
          base_next.invalid = 1'b1;
        end else begin
          base_next.bz = quo_next;
        end
      end
      S_DIV_Y: begin
        base_next.by = quo_next;
        base_next.bx = rem_next[DIM_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job_wdata    = base;
    job_wdata.pc = {base.bz[0], base.by[0], base.bx[0]};
    job_wdata.tc = TC_W'(mod3(base.bx))
                 + TC_W'(mod3(base.by)) * TC_W'(3)
                 + TC_W'(mod3(base.bz)) * TC_W'(9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= 1'b0;
    end else begin
      if (push && !full) begin
        slot_valid <= 1'b1;
        slot_idx   <= cell_index;
      end else if (take) begin
        slot_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (slot_valid) begin
            rem  <= slot_idx;
            quo  <= '0;
            step <= STEP_TOP;
            base <= base_next;
            if (over) begin
              state <= S_EMIT;
            end else begin
              state <= S_DIV_Z;
            end
          end
        end
        S_DIV_Z: begin
          rem <= rem_next;
          if (step == '0) begin
            quo  <= '0;
            step <= STEP_TOP;
            base <= base_next;
            if (z_over) begin
              state <= S_EMIT;
            end else begin
              state <= S_DIV_Y;
            end
          end else begin
            quo  <= quo_next;
            step <= step - 1'b1;
          end
        end
        S_DIV_Y: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step - 1'b1;
          if (step == '0) begin
            base  <= base_next;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!job_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_coords_in_grid: assert property (@(posedge clk) disable iff (rst)
    job_push && !job_wdata.invalid |->
      job_wdata.bx < dims.cx && job_wdata.by < dims.cy && job_wdata.bz < dims.cz)
    else $error("decoded coordinates outside the grid");

endmodule

`default_nettype wire

// ===== hdl/cgn_walker.sv =====
`default_nettype none

module cgn_walker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cgn_pkg::dims_t dims,
  input  wire logic       job_empty,
  input  wire cgn_pkg::job_t job_rdata,
  output logic            job_pop,
  input  wire logic       out_full,
  output logic            out_push,
  output cgn_pkg::result_t out_wdata
);

  import cgn_pkg::*;

  logic             active;
  job_t             job;
  ofs_t             dx;
  ofs_t             dy;
  ofs_t             dz;
  ofs_t             dx_hi;
  ofs_t             dy_hi;
  ofs_t             dz_hi;
  logic             last;
  logic [IDX_W-1:0] zoff;
  logic [IDX_W-1:0] yoff;
  logic [IDX_W-1:0] neighbour;

  // The walk runs only over offsets that stay inside the grid, so every
  // clock with room downstream produces one beat while a job is active.
  assign dx_hi = ({1'b0, job.bx} + 1'b1 == {1'b0, dims.cx}) ? OFS_ZERO : OFS_POS;
  assign dy_hi = ({1'b0, job.by} + 1'b1 == {1'b0, dims.cy}) ? OFS_ZERO : OFS_POS;
  assign dz_hi = ({1'b0, job.bz} + 1'b1 == {1'b0, dims.cz}) ? OFS_ZERO : OFS_POS;

  assign last     = job.invalid || (dx == dx_hi && dy == dy_hi && dz == dz_hi);
  assign out_push = active && !out_full;
  assign job_pop  = !job_empty && (!active || (out_push && last));

  always_comb begin
    case (dz)
      OFS_POS: zoff = IDX_W'(dims.plane);
      OFS_NEG: zoff = '0 - IDX_W'(dims.plane);
      default: zoff = '0;
    endcase
    case (dy)
      OFS_POS: yoff = IDX_W'(dims.cx);
      OFS_NEG: yoff = '0 - IDX_W'(dims.cx);
      default: yoff = '0;
    endcase
    // Modular 18-bit sum: the true neighbour number is non-negative.
    neighbour = job.idx + zoff + yoff + IDX_W'(dx);
  end

  always_comb begin
    out_wdata.neighbour = job.invalid ? '0 : neighbour;
    out_wdata.last      = last;
    out_wdata.bx        = job.bx[OUT_CW-1:0];
    out_wdata.by        = job.by[OUT_CW-1:0];
    out_wdata.bz        = job.bz[OUT_CW-1:0];
    out_wdata.pc        = job.pc;
    out_wdata.tc        = job.tc;
    out_wdata.invalid   = job.invalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (job_pop) begin
      active <= 1'b1;
      job    <= job_rdata;
      dx     <= low_ofs(job_rdata.bx);
      dy     <= low_ofs(job_rdata.by);
      dz     <= low_ofs(job_rdata.bz);
    end else if (out_push) begin
      if (last) begin
        active <= 1'b0;
      end else if (dx != dx_hi) begin
        dx <= dx + OFS_POS;
      end else begin
        dx <= low_ofs(job.bx);
        if (dy != dy_hi) begin
          dy <= dy + OFS_POS;
        end else begin
          dy <= low_ofs(job.by);
          dz <= dz + OFS_POS;
        end
      end
    end
  end

  a_offsets_in_range: assert property (@(posedge clk) disable iff (rst)
    active && !job.invalid |-> dx != 2'b10 && dy != 2'b10 && dz != 2'b10)
    else $error("neighbour offset out of range");
  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    out_push && !last |=> active)
    else $error("walk stopped before the final neighbour");

endmodule

`default_nettype wire

// ===== hdl/cell_grid_neighbour_generator.sv =====
`default_nettype none

// Linked-cell neighbour generator. Push a linear cell number and pop one beat
// per in-grid neighbour of its 3x3x3 block (z outer, x inner, the final beat
// flagged by last), or a single beat with invalid set when the number is not
// inside the grid. The decoder splits the number into x, y and z with a
// shared restoring divider, one quotient bit per clock, and the neighbour
// walker emits one beat per clock while the output queue has room. The two
// overlap through a two-entry job queue, so the decoder can take the next
// cell while the walker still emits beats of earlier ones; a valid cell
// gives 1 to 27 beats (8 to 27 when every dimension is at least two).
// Dimension writes of 0 are stored as 1 and values above MAX_CELLS_PER_DIM
// are stored as that limit; write them only while idle.

module cell_grid_neighbour_generator #(
  parameter int MAX_CELLS_PER_DIM = cgn_pkg::MAX_CELLS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [cgn_pkg::IDX_W-1:0]         cell_index,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [cgn_pkg::IDX_W-1:0]              neighbour_cell,
  output logic                                   last,
  output logic [cgn_pkg::OUT_CW-1:0]             base_x,
  output logic [cgn_pkg::OUT_CW-1:0]             base_y,
  output logic [cgn_pkg::OUT_CW-1:0]             base_z,
  output logic [cgn_pkg::PC_W-1:0]               parity_color,
  output logic [cgn_pkg::TC_W-1:0]               triple_color,
  output logic                                   invalid,
  input  wire logic                              write_enable,
  input  wire logic [cgn_pkg::REG_IDX_W-1:0]     reg_index,
  input  wire logic [cgn_pkg::DIM_W-1:0]         write_data
);

  import cgn_pkg::*;

  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  dims_t   dims;
  logic    job_push;
  job_t    job_wdata;
  logic    job_full;
  logic    job_pop;
  job_t    job_rdata;
  logic    job_empty;
  logic    out_push;
  result_t out_wdata;
  logic    out_full;
  result_t out_rdata;

  cgn_config #(
    .MAX_CELLS_PER_DIM(MAX_CELLS_PER_DIM)
  ) u_config (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .dims        (dims)
  );

  cgn_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .push      (push),
    .full      (full),
    .cell_index(cell_index),
    .job_push  (job_push),
    .job_wdata (job_wdata),
    .job_full  (job_full)
  );

  cgn_fifo #(
    .W    ($bits(job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_job_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_data(job_wdata),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_data(job_rdata),
    .empty  (job_empty)
  );

  cgn_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .job_empty(job_empty),
    .job_rdata(job_rdata),
    .job_pop  (job_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_wdata(out_wdata)
  );

  cgn_fifo #(
    .W    ($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (out_push),
    .wr_data(out_wdata),
    .full   (out_full),
    .rd_en  (pop && !empty),
    .rd_data(out_rdata),
    .empty  (empty)
  );

  assign neighbour_cell = out_rdata.neighbour;
  assign last           = out_rdata.last;
  assign base_x         = out_rdata.bx;
  assign base_y         = out_rdata.by;
  assign base_z         = out_rdata.bz;
  assign parity_color   = out_rdata.pc;
  assign triple_color   = out_rdata.tc;
  assign invalid        = out_rdata.invalid;

endmodule

`default_nettype wire
